/* rtl/tbd_pkg.sv */
// shared types and constants of the touch baseline detector
package tbd_pkg;

  localparam int unsigned CountW   = 14;  // width of one group count
  localparam int unsigned ThreshW  = 14;  // width of the on threshold
  localparam int unsigned MaskW    = 32;  // one bit per channel
  localparam int unsigned PhaseW   = 2;   // io phase field
  localparam int unsigned ChanIdxW = 5;   // channel id
  localparam int unsigned MaxGroups = 8;  // count fields in one request
  localparam int unsigned InDataW  = MaxGroups * CountW;
  localparam int unsigned OutDataW = 72;  // 67 payload bits padded to bytes
  localparam int unsigned PaddrW   = 3;

  // register select, taken from the word address bit of paddr
  localparam logic RegEnable = 1'b0;
  localparam logic RegThresh = 1'b1;

  typedef struct packed {
    logic               adv;  // request moves to the result register
    logic               en;   // channel at the current phase is enabled
    logic [ThreshW-1:0] thr;
  } lane_ctl_t;

  typedef struct packed {
    logic upd;      // baseline captured, active bit gets rewritten
    logic touched;  // drop below baseline exceeds the threshold
  } lane_res_t;

endpackage

/* rtl/tbd_lane.sv */
// one group lane: baseline storage per io position and the touch compare
module tbd_lane #(
  parameter int unsigned IOS_PER_GROUP = 4
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  tbd_pkg::lane_ctl_t                     ctl_i,
  input  logic [(IOS_PER_GROUP > 1 ? $clog2(IOS_PER_GROUP) : 1)-1:0] idx_i,
  input  logic [tbd_pkg::CountW-1:0]             count_i,
  output tbd_pkg::lane_res_t                     res_o
);
  import tbd_pkg::*;

  logic [CountW-1:0] base_q [IOS_PER_GROUP];
  logic [CountW-1:0] base_cur;
  logic              captured;
  logic [CountW:0]   count_plus_thr;

  assign base_cur = base_q[idx_i];
  assign captured = (base_cur != '0);

  // baseline - count > thr  <=>  count + thr < baseline
  assign count_plus_thr = {1'b0, count_i} + {1'b0, ctl_i.thr};

  assign res_o.upd     = ctl_i.en && captured;
  assign res_o.touched = count_plus_thr < {1'b0, base_cur};

  // a zero count leaves the entry uncaptured, so capture retries next time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < IOS_PER_GROUP; i++) begin
        base_q[i] <= '0;
      end
    end else if (ctl_i.adv && ctl_i.en && !captured) begin
      base_q[idx_i] <= count_i;
    end
  end

endmodule

/* rtl/touch_baseline_detector.sv */
// touch_baseline_detector: baseline capture and threshold touch detection
//
// Input stream (s_axis): one request per end-of-acquisition event, carrying the
// counts of all groups for the io position currently scanned. Output stream
// (m_axis): one result per request with the active mask, the channel mask and
// phase of the next scan and a start flag. Channel id = phase + group * ios.
// An APB port holds the enable mask (0x0) and the on threshold (0x4); write it
// only while no request is in flight.
// A request is registered on accept and evaluated against the baselines once
// the result register is free or drained, when baselines, active bits and
// phase are updated and the result register loaded.
// Throughput is one request per cycle while the receiver does not stall; the
// input register feeds the result register directly.
// If the receiver stalls, one result waits in the result register and one more
// request is held in the input register; after that s_axis_tready_o drops.
// Reset clears all baselines (not captured), active bits, the phase, the
// enable mask and sets the threshold to 10.
module touch_baseline_detector #(
  parameter int unsigned NUM_GROUPS    = 8,
  parameter int unsigned IOS_PER_GROUP = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // s_axis_tdata_i: count_group0 .. count_group7, 14 bits each, from bit 0 up
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [tbd_pkg::InDataW-1:0]   s_axis_tdata_i,
  // m_axis_tdata_o: active_mask[31:0], next_channel_mask[63:32],
  // start_next[64], next_phase[66:65], zero padding[71:67]
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [tbd_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [tbd_pkg::PaddrW-1:0]    paddr_i,
  input  logic [31:0]                   pwdata_i,
  output logic [31:0]                   prdata_o,
  output logic                          pready_o
);
  import tbd_pkg::*;

  localparam int unsigned IdxW = (IOS_PER_GROUP > 1) ? $clog2(IOS_PER_GROUP) : 1;

  // configuration
  logic [MaskW-1:0]   enable_q;
  logic [ThreshW-1:0] thresh_q;
  logic               cfg_wr;

  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      thresh_q <= ThreshW'(10);
    end else if (cfg_wr) begin
      unique case (paddr_i[2])
        RegEnable: enable_q <= pwdata_i;
        RegThresh: thresh_q <= pwdata_i[ThreshW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[2])
      RegEnable: prdata_o = enable_q;
      RegThresh: prdata_o = {{(32-ThreshW){1'b0}}, thresh_q};
      default:   prdata_o = '0;
    endcase
  end

  // input register
  logic              in_valid_q;
  logic [CountW-1:0] in_count_q [NUM_GROUPS];
  logic              adv;
  logic              out_valid_q;

  assign adv             = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        in_count_q[g] <= s_axis_tdata_i[g*CountW +: CountW];
      end
    end
  end

  // state
  logic [MaskW-1:0]  active_q, active_d;
  logic [PhaseW-1:0] phase_q, phase_d;

  // group lanes
  logic [ChanIdxW-1:0] chan_id [NUM_GROUPS];
  lane_ctl_t           lane_ctl [NUM_GROUPS];
  lane_res_t           lane_res [NUM_GROUPS];

  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_lane
    assign chan_id[g]      = ChanIdxW'(g * IOS_PER_GROUP) + ChanIdxW'(phase_q);
    assign lane_ctl[g].adv = adv;
    assign lane_ctl[g].en  = enable_q[chan_id[g]];
    assign lane_ctl[g].thr = thresh_q;

    tbd_lane #(
      .IOS_PER_GROUP(IOS_PER_GROUP)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (lane_ctl[g]),
      .idx_i  (phase_q[IdxW-1:0]),
      .count_i(in_count_q[g]),
      .res_o  (lane_res[g])
    );
  end

  logic [MaskW-1:0] pattern;

  always_comb begin
    active_d = active_q;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (lane_res[g].upd) begin
        active_d[chan_id[g]] = lane_res[g].touched;
      end
    end

    if ((32'(phase_q) + 32'd1 < IOS_PER_GROUP) && (phase_q != PhaseW'(3))) begin
      phase_d = phase_q + PhaseW'(1);
    end else begin
      phase_d = '0;
    end

    pattern = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      pattern[ChanIdxW'(g * IOS_PER_GROUP) + ChanIdxW'(phase_d)] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      phase_q  <= '0;
    end else if (adv) begin
      active_q <= active_d;
      phase_q  <= phase_d;
    end
  end

  // result register
  logic [OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= {{(OutDataW-2*MaskW-PhaseW-1){1'b0}}, phase_d, (enable_q != '0),
                     pattern & enable_q, active_d};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // checks
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(phase_q) < IOS_PER_GROUP)
    else $error("io phase out of range");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("request accepted with both stages full");

  a_result_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (m_axis_tdata_o[2*MaskW+1 +: PhaseW] == phase_q))
    else $error("result phase differs from stored phase");

  a_result_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (m_axis_tdata_o[MaskW-1:0] == active_q))
    else $error("result active mask differs from stored active bits");

endmodule
